// ===== rtl/ltgs_pkg.sv =====
// shared constants, types and helper functions of the labeled-topic gibbs sampler
`timescale 1ns / 1ps

package ltgs_pkg;

    localparam int NUM_WORDS   = 1024;
    localparam int NUM_LABELS  = 16;
    localparam int NUM_DOCS    = 256;
    localparam int NUM_TOKENS  = 65536;

    localparam int WORD_W      = $clog2(NUM_WORDS);
    localparam int DOC_W       = $clog2(NUM_DOCS);
    localparam int TOK_W       = $clog2(NUM_TOKENS);
    localparam int WLC_DEPTH   = NUM_WORDS * NUM_LABELS;
    localparam int DLC_DEPTH   = NUM_DOCS * NUM_LABELS;
    localparam int WLC_AW      = $clog2(WLC_DEPTH);
    localparam int DLC_AW      = $clog2(DLC_DEPTH);
    localparam int CLR_W       = WLC_AW + 1;

    // labels come from a 16-bit mask
    localparam int SCAN_LABELS = (NUM_LABELS < 16) ? NUM_LABELS : 16;
    localparam logic [15:0] SCAN_MASK = 16'((32'd1 << SCAN_LABELS) - 1);

    localparam int CNT_W   = 16;
    localparam int TOTL_W  = 24;
    localparam int F_W     = 25;
    localparam int NUMW_W  = 33;
    localparam int VB_W    = 35;
    localparam int DEN_W   = 41;
    localparam int REM_W   = 42;
    localparam int P1_W    = 41;
    localparam int P2_W    = 49;
    localparam int W_W     = 42;
    localparam int SUM_W   = 46;
    localparam int HALF_W  = 23;
    localparam int PH_W    = 39;
    localparam int UT_W    = 62;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [TOTL_W-1:0] TOTL_MAX = '1;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_VOCAB = 2'd2;

    localparam logic OP_INIT     = 1'b0;
    localparam logic OP_RESAMPLE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] token_slot;
        logic [7:0]  doc_id;
        logic [9:0]  word_id;
        logic [15:0] label_mask;
        logic [15:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  new_label;
        logic [15:0] slot_echo;
    } out_item_t;

    typedef struct packed {
        logic [23:0] alpha_q16;
        logic [23:0] beta_q16;
        logic [10:0] vocab_size;
    } cfg_t;

    typedef struct packed {
        logic [WLC_AW-1:0] wlc_addr;
        logic              wlc_we;
        logic [CNT_W-1:0]  wlc_wdata;
        logic [DLC_AW-1:0] dlc_addr;
        logic              dlc_we;
        logic [CNT_W-1:0]  dlc_wdata;
        logic [DOC_W-1:0]  dtot_addr;
        logic              dtot_we;
        logic [CNT_W-1:0]  dtot_wdata;
        logic [TOK_W-1:0]  tok_addr;
        logic              tok_we;
        logic [3:0]        tok_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] wlc_q;
        logic [CNT_W-1:0] dlc_q;
        logic [CNT_W-1:0] dtot_q;
        logic [3:0]       tok_q;
        logic             clear_done;
    } mem_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_OLD_ADDR,
        S_OLD_WR,
        S_W_RD,
        S_W_LOAD,
        S_W_DIV,
        S_W_MUL,
        S_W_ACC,
        S_UT,
        S_UT2,
        S_SEL,
        S_INC_RD,
        S_INC_WR,
        S_DONE
    } state_t;

    // lowest set bit: {found, index}
    function automatic logic [4:0] first_set(input logic [15:0] m);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (m[i]) r = {1'b1, 4'(i)};
        end
        return r;
    endfunction

    // lowest set bit strictly above lab: {found, index}
    function automatic logic [4:0] next_set(input logic [15:0] m, input logic [3:0] lab);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (m[i] && (4'(i) > lab)) r = {1'b1, 4'(i)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/ltgs_cfg.sv =====
// apb register file holding the smoothing priors and vocabulary size
`timescale 1ns / 1ps

module ltgs_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ltgs_pkg::cfg_t      cfg
);

    ltgs_pkg::cfg_t cfg_reg;
    logic [1:0]     idx;
    logic           wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q16  <= 24'd32768;
            cfg_reg.beta_q16   <= 24'd655;
            cfg_reg.vocab_size <= 11'd1024;
        end
        else if (wr)
        begin
            if (idx == ltgs_pkg::REG_ALPHA) cfg_reg.alpha_q16  <= pwdata[23:0];
            if (idx == ltgs_pkg::REG_BETA)  cfg_reg.beta_q16   <= pwdata[23:0];
            if (idx == ltgs_pkg::REG_VOCAB) cfg_reg.vocab_size <= pwdata[10:0];
        end
    end

    always_comb
    begin
        unique case (idx)
            ltgs_pkg::REG_ALPHA: prdata = {8'd0, cfg_reg.alpha_q16};
            ltgs_pkg::REG_BETA:  prdata = {8'd0, cfg_reg.beta_q16};
            ltgs_pkg::REG_VOCAB: prdata = {21'd0, cfg_reg.vocab_size};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/ltgs_div.sv =====
// restoring divider for the word factor, one quotient bit a cycle, saturating
`timescale 1ns / 1ps

module ltgs_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ltgs_pkg::NUMW_W-1:0]        numw,
    input  logic [ltgs_pkg::DEN_W-1:0]         den,
    output logic [ltgs_pkg::F_W-1:0]           quot,
    output logic                               done
);

    logic [ltgs_pkg::REM_W-1:0] rem_reg;
    logic [ltgs_pkg::DEN_W-1:0] den_reg;
    logic [ltgs_pkg::F_W-1:0]   q_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       first_reg;
    logic                       done_reg;
    logic [ltgs_pkg::REM_W:0]   trial;
    logic                       fit;
    logic                       sat;

    // quotient overflows 25 bits once numw reaches twice the denominator
    assign sat = (den == '0) ||
                 ({{(ltgs_pkg::REM_W-ltgs_pkg::NUMW_W){1'b0}}, numw} >= {den, 1'b0});

    always_comb
    begin
        trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fit   = trial >= {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= !sat;
            done_reg <= sat;
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != 5'd0);
            done_reg <= (cnt_reg == 5'd0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg   <= den;
            rem_reg   <= ltgs_pkg::REM_W'(numw);
            q_reg     <= sat ? '1 : '0;
            cnt_reg   <= 5'(ltgs_pkg::F_W - 1);
            first_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg   <= fit ? ltgs_pkg::REM_W'(trial - {2'b00, den_reg})
                             : ltgs_pkg::REM_W'(trial);
            q_reg     <= {q_reg[ltgs_pkg::F_W-2:0], fit};
            cnt_reg   <= cnt_reg - 5'd1;
            first_reg <= 1'b0;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/ltgs_mem.sv =====
// count and assignment memories with the clearing pass after reset
`timescale 1ns / 1ps

module ltgs_mem
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ltgs_pkg::mem_req_t   req,
    output ltgs_pkg::mem_rsp_t   rsp
);

    logic [ltgs_pkg::CNT_W-1:0] wlc_mem  [ltgs_pkg::WLC_DEPTH];
    logic [ltgs_pkg::CNT_W-1:0] dlc_mem  [ltgs_pkg::DLC_DEPTH];
    logic [ltgs_pkg::CNT_W-1:0] dtot_mem [ltgs_pkg::NUM_DOCS];
    logic [3:0]                 tok_mem  [ltgs_pkg::NUM_TOKENS];

    logic [ltgs_pkg::CLR_W-1:0] clr_reg;
    logic                       clearing;
    logic [ltgs_pkg::CNT_W-1:0] wlc_q_reg;
    logic [ltgs_pkg::CNT_W-1:0] dlc_q_reg;
    logic [ltgs_pkg::CNT_W-1:0] dtot_q_reg;
    logic [3:0]                 tok_q_reg;

    assign clearing = (clr_reg < ltgs_pkg::CLR_W'(ltgs_pkg::WLC_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            wlc_mem[clr_reg[ltgs_pkg::WLC_AW-1:0]] <= '0;
            if (clr_reg < ltgs_pkg::CLR_W'(ltgs_pkg::DLC_DEPTH))
                dlc_mem[clr_reg[ltgs_pkg::DLC_AW-1:0]] <= '0;
            if (clr_reg < ltgs_pkg::CLR_W'(ltgs_pkg::NUM_DOCS))
                dtot_mem[clr_reg[ltgs_pkg::DOC_W-1:0]] <= '0;
        end
        else
        begin
            if (req.wlc_we)  wlc_mem[req.wlc_addr]   <= req.wlc_wdata;
            if (req.dlc_we)  dlc_mem[req.dlc_addr]   <= req.dlc_wdata;
            if (req.dtot_we) dtot_mem[req.dtot_addr] <= req.dtot_wdata;
        end
        if (req.tok_we) tok_mem[req.tok_addr] <= req.tok_wdata;

        wlc_q_reg  <= wlc_mem[req.wlc_addr];
        dlc_q_reg  <= dlc_mem[req.dlc_addr];
        dtot_q_reg <= dtot_mem[req.dtot_addr];
        tok_q_reg  <= tok_mem[req.tok_addr];
    end

    assign rsp.wlc_q      = wlc_q_reg;
    assign rsp.dlc_q      = dlc_q_reg;
    assign rsp.dtot_q     = dtot_q_reg;
    assign rsp.tok_q      = tok_q_reg;
    assign rsp.clear_done = !clearing;

endmodule

// ===== rtl/labeled_topic_gibbs_sampler_top.sv =====
// Labeled-topic Gibbs sampler: one item in, one label out, counts kept in
// on-chip memories. After reset a clearing pass zeroes the count memories,
// during which in_stall stays high (register writes are taken). An init
// item walks its k allowed labels up to the position that its random value
// picks. A resample item first takes its old label out of the counts; then
// each allowed label needs a count read, a 25-step bit-serial division and a
// multiply, and the label is then picked by a walk over the stored weights;
// a word factor that saturates skips its division.
// Items are handled one at a time; a finished result waits in the output
// register while the next item is taken.
`timescale 1ns / 1ps

module labeled_topic_gibbs_sampler_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ltgs_pkg::in_item_t     in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ltgs_pkg::out_item_t    out_item,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    ltgs_pkg::cfg_t      cfg;
    ltgs_pkg::mem_req_t  req;
    ltgs_pkg::mem_rsp_t  rsp;

    ltgs_pkg::state_t state_reg, state_next;
    logic                          op_reg, op_next;
    logic [15:0]                   slot_reg, slot_next;
    logic [ltgs_pkg::DOC_W-1:0]    doc_reg, doc_next;
    logic [ltgs_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [15:0]                   mask_reg, mask_next;
    logic [15:0]                   u_reg, u_next;
    logic [3:0]                    idx_reg, idx_next;
    logic [ltgs_pkg::VB_W-1:0]     vb_reg, vb_next;
    logic [3:0]                    old_reg, old_next;
    logic [3:0]                    lab_reg, lab_next;
    logic [3:0]                    first_reg, first_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [3:0]                    nl_reg, nl_next;
    logic [ltgs_pkg::CNT_W-1:0]    cdt_reg, cdt_next;
    logic [ltgs_pkg::P1_W-1:0]     p1_reg, p1_next;
    logic [ltgs_pkg::P2_W-1:0]     p2_reg, p2_next;
    logic [ltgs_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [ltgs_pkg::SUM_W-1:0]    cum_reg, cum_next;
    logic [ltgs_pkg::PH_W-1:0]     pa_reg, pa_next;
    logic [ltgs_pkg::PH_W-1:0]     pb_reg, pb_next;
    logic [ltgs_pkg::UT_W-1:0]     ut_reg, ut_next;
    logic [ltgs_pkg::W_W-1:0]      w_reg [16];
    logic [ltgs_pkg::TOTL_W-1:0]   ltot_reg [ltgs_pkg::NUM_LABELS];
    logic                          out_valid_reg, out_valid_next;
    ltgs_pkg::out_item_t           out_item_reg, out_item_next;

    logic                          w_we;
    logic [ltgs_pkg::W_W-1:0]      w_new;
    logic                          lt_we;
    logic [3:0]                    lt_idx;
    logic [ltgs_pkg::TOTL_W-1:0]   lt_wdata;

    logic                          div_start;
    logic [ltgs_pkg::NUMW_W-1:0]   div_numw;
    logic [ltgs_pkg::DEN_W-1:0]    div_den;
    logic [ltgs_pkg::F_W-1:0]      div_q;
    logic                          div_done;

    logic [3:0]                    mem_lab;
    logic [4:0]                    fst;
    logic [4:0]                    nxt;
    logic [4:0]                    kcnt;
    logic [ltgs_pkg::SUM_W-1:0]    cum_sum;
    logic                          hit;
    logic [ltgs_pkg::TOTL_W-1:0]   ltot_sel;

    ltgs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ltgs_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ltgs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numw  (div_numw),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    // label that the count memories are addressed with in this state
    always_comb
    begin
        unique case (state_reg)
            ltgs_pkg::S_OLD_ADDR:                  mem_lab = rsp.tok_q;
            ltgs_pkg::S_OLD_WR:                    mem_lab = old_reg;
            ltgs_pkg::S_W_RD, ltgs_pkg::S_W_LOAD:  mem_lab = lab_reg;
            default:                               mem_lab = nl_reg;
        endcase
    end

    assign ltot_sel = ltot_reg[mem_lab];
    assign fst      = ltgs_pkg::first_set(mask_reg);
    assign nxt      = ltgs_pkg::next_set(mask_reg, lab_reg);
    assign kcnt     = 5'($countones(mask_reg));
    assign cum_sum  = cum_reg + ltgs_pkg::SUM_W'(w_reg[lab_reg]);
    assign hit      = (op_reg == ltgs_pkg::OP_INIT) ? (cnt_reg == idx_reg)
                                                    : ({cum_sum, 16'd0} >= ut_reg);
    assign w_new    = ltgs_pkg::W_W'(p1_reg) + ltgs_pkg::W_W'(p2_reg >> 16);

    assign div_numw = {1'b0, rsp.wlc_q, 16'd0} + ltgs_pkg::NUMW_W'(cfg.beta_q16);
    assign div_den  = {1'b0, ltot_sel, 16'd0} + ltgs_pkg::DEN_W'(vb_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        doc_next       = doc_reg;
        word_next      = word_reg;
        mask_next      = mask_reg;
        u_next         = u_reg;
        idx_next       = idx_reg;
        vb_next        = vb_reg;
        old_next       = old_reg;
        lab_next       = lab_reg;
        first_next     = first_reg;
        cnt_next       = cnt_reg;
        nl_next        = nl_reg;
        cdt_next       = cdt_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        sum_next       = sum_reg;
        cum_next       = cum_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        ut_next        = ut_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        w_we           = 1'b0;
        lt_we          = 1'b0;
        lt_idx         = mem_lab;
        lt_wdata       = ltot_sel;
        div_start      = 1'b0;
        in_stall       = 1'b1;

        req.wlc_addr   = ltgs_pkg::WLC_AW'(word_reg * ltgs_pkg::NUM_LABELS)
                       + ltgs_pkg::WLC_AW'(mem_lab);
        req.dlc_addr   = ltgs_pkg::DLC_AW'(doc_reg * ltgs_pkg::NUM_LABELS)
                       + ltgs_pkg::DLC_AW'(mem_lab);
        req.dtot_addr  = doc_reg;
        req.tok_addr   = ltgs_pkg::TOK_W'(slot_reg);
        req.wlc_we     = 1'b0;
        req.dlc_we     = 1'b0;
        req.dtot_we    = 1'b0;
        req.tok_we     = 1'b0;
        req.wlc_wdata  = rsp.wlc_q;
        req.dlc_wdata  = rsp.dlc_q;
        req.dtot_wdata = rsp.dtot_q;
        req.tok_wdata  = nl_reg;

        unique case (state_reg)
            ltgs_pkg::S_IDLE:
            begin
                in_stall = !rsp.clear_done;
                if (in_valid && rsp.clear_done)
                begin
                    op_next    = in_item.operation;
                    slot_next  = 16'(ltgs_pkg::TOK_W'(in_item.token_slot));
                    doc_next   = ltgs_pkg::DOC_W'(in_item.doc_id);
                    word_next  = ltgs_pkg::WORD_W'(in_item.word_id);
                    mask_next  = ((in_item.label_mask & ltgs_pkg::SCAN_MASK) == 16'd0)
                               ? 16'd1 : (in_item.label_mask & ltgs_pkg::SCAN_MASK);
                    u_next     = in_item.random_value;
                    state_next = ltgs_pkg::S_PREP;
                end
            end
            ltgs_pkg::S_PREP:
            begin
                idx_next   = 4'((21'(u_reg) * 21'(kcnt)) >> 16);
                vb_next    = ltgs_pkg::VB_W'(cfg.vocab_size) * ltgs_pkg::VB_W'(cfg.beta_q16);
                first_next = fst[3:0];
                lab_next   = fst[3:0];
                cnt_next   = 4'd0;
                sum_next   = '0;
                cum_next   = '0;
                ut_next    = '0;
                state_next = (op_reg == ltgs_pkg::OP_RESAMPLE) ? ltgs_pkg::S_OLD_ADDR
                                                               : ltgs_pkg::S_SEL;
            end
            ltgs_pkg::S_OLD_ADDR:
            begin
                old_next   = rsp.tok_q;
                state_next = ltgs_pkg::S_OLD_WR;
            end
            ltgs_pkg::S_OLD_WR:
            begin
                // take the old label out of the counts, floor at zero
                req.wlc_we    = 1'b1;
                req.wlc_wdata = (rsp.wlc_q == '0) ? '0 : rsp.wlc_q - 1'b1;
                req.dlc_we    = 1'b1;
                req.dlc_wdata = (rsp.dlc_q == '0) ? '0 : rsp.dlc_q - 1'b1;
                lt_we         = 1'b1;
                lt_wdata      = (ltot_sel == '0) ? '0 : ltot_sel - 1'b1;
                state_next    = ltgs_pkg::S_W_RD;
            end
            ltgs_pkg::S_W_RD:
            begin
                state_next = ltgs_pkg::S_W_LOAD;
            end
            ltgs_pkg::S_W_LOAD:
            begin
                div_start  = 1'b1;
                cdt_next   = rsp.dlc_q;
                state_next = ltgs_pkg::S_W_DIV;
            end
            ltgs_pkg::S_W_DIV:
            begin
                if (div_done) state_next = ltgs_pkg::S_W_MUL;
            end
            ltgs_pkg::S_W_MUL:
            begin
                p1_next    = ltgs_pkg::P1_W'(div_q) * ltgs_pkg::P1_W'(cdt_reg);
                p2_next    = ltgs_pkg::P2_W'(div_q) * ltgs_pkg::P2_W'(cfg.alpha_q16);
                state_next = ltgs_pkg::S_W_ACC;
            end
            ltgs_pkg::S_W_ACC:
            begin
                w_we     = 1'b1;
                sum_next = sum_reg + ltgs_pkg::SUM_W'(w_new);
                if (nxt[4])
                begin
                    lab_next   = nxt[3:0];
                    state_next = ltgs_pkg::S_W_RD;
                end
                else
                begin
                    state_next = ltgs_pkg::S_UT;
                end
            end
            ltgs_pkg::S_UT:
            begin
                // u times the weight sum, in two halves
                pa_next    = ltgs_pkg::PH_W'(u_reg) *
                             ltgs_pkg::PH_W'(sum_reg[ltgs_pkg::HALF_W-1:0]);
                pb_next    = ltgs_pkg::PH_W'(u_reg) *
                             ltgs_pkg::PH_W'(sum_reg[ltgs_pkg::SUM_W-1:ltgs_pkg::HALF_W]);
                state_next = ltgs_pkg::S_UT2;
            end
            ltgs_pkg::S_UT2:
            begin
                ut_next    = ltgs_pkg::UT_W'(pa_reg)
                           + (ltgs_pkg::UT_W'(pb_reg) << ltgs_pkg::HALF_W);
                lab_next   = first_reg;
                state_next = ltgs_pkg::S_SEL;
            end
            ltgs_pkg::S_SEL:
            begin
                cum_next = cum_sum;
                cnt_next = cnt_reg + 4'd1;
                if (hit)
                begin
                    nl_next    = lab_reg;
                    state_next = ltgs_pkg::S_INC_RD;
                end
                else if (nxt[4])
                begin
                    lab_next = nxt[3:0];
                end
                else
                begin
                    nl_next    = first_reg;
                    state_next = ltgs_pkg::S_INC_RD;
                end
            end
            ltgs_pkg::S_INC_RD:
            begin
                state_next = ltgs_pkg::S_INC_WR;
            end
            ltgs_pkg::S_INC_WR:
            begin
                req.wlc_we     = 1'b1;
                req.wlc_wdata  = (rsp.wlc_q == ltgs_pkg::CNT_MAX) ? rsp.wlc_q : rsp.wlc_q + 1'b1;
                req.dlc_we     = 1'b1;
                req.dlc_wdata  = (rsp.dlc_q == ltgs_pkg::CNT_MAX) ? rsp.dlc_q : rsp.dlc_q + 1'b1;
                req.dtot_we    = (op_reg == ltgs_pkg::OP_INIT);
                req.dtot_wdata = (rsp.dtot_q == ltgs_pkg::CNT_MAX)
                               ? rsp.dtot_q : rsp.dtot_q + 1'b1;
                req.tok_we     = 1'b1;
                lt_we          = 1'b1;
                lt_wdata       = (ltot_sel == ltgs_pkg::TOTL_MAX) ? ltot_sel : ltot_sel + 1'b1;
                state_next     = ltgs_pkg::S_DONE;
            end
            ltgs_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.new_label = nl_reg;
                    out_item_next.slot_echo = slot_reg;
                    state_next              = ltgs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ltgs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltgs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ltgs_pkg::NUM_LABELS; i++) ltot_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (lt_we) ltot_reg[lt_idx] <= lt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        doc_reg      <= doc_next;
        word_reg     <= word_next;
        mask_reg     <= mask_next;
        u_reg        <= u_next;
        idx_reg      <= idx_next;
        vb_reg       <= vb_next;
        old_reg      <= old_next;
        lab_reg      <= lab_next;
        first_reg    <= first_next;
        cnt_reg      <= cnt_next;
        nl_reg       <= nl_next;
        cdt_reg      <= cdt_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        sum_reg      <= sum_next;
        cum_reg      <= cum_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        ut_reg       <= ut_next;
        out_item_reg <= out_item_next;
        if (w_we) w_reg[lab_reg] <= w_new;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/ltgs_checker.sv =====
// port-level checks of the labeled-topic gibbs sampler, bound to the top level
`timescale 1ns / 1ps

module ltgs_port_checks
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  ltgs_pkg::out_item_t    out_item,
    input  logic                   pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // an accepted item keeps the block busy, so in_stall is high after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("block free too soon after accepting an item");

    // a fresh result only comes from work in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while block was idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind labeled_topic_gibbs_sampler_top ltgs_port_checks u_ltgs_port_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .pready    (pready)
);

// ===== test/ltgs_checker.sv =====
// checker for the labeled-topic gibbs sampler: label predictor and result comparison
`timescale 1ns / 1ps

module ltgs_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ltgs_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ltgs_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [31:0]         cfg_val,
    output int                  fail_count,
    output int                  pending
);

    logic [23:0] alpha_r;
    logic [23:0] beta_r;
    logic [10:0] vocab_r;

    logic [15:0] wl_cnt [ltgs_pkg::WLC_DEPTH];
    logic [15:0] dl_cnt [ltgs_pkg::DLC_DEPTH];
    logic [23:0] lab_tot [ltgs_pkg::NUM_LABELS];
    logic [15:0] doc_tot [ltgs_pkg::NUM_DOCS];
    logic [3:0]  tok_lab [ltgs_pkg::NUM_TOKENS];

    ltgs_pkg::out_item_t label_queue [$];

    assign pending = label_queue.size();

    function automatic logic [63:0] weigh(int d, int w, int lab);
        logic [63:0] numw, den, numd, f;
        numw = (64'(wl_cnt[w*ltgs_pkg::NUM_LABELS+lab]) << 16) + 64'(beta_r);
        den  = (64'(lab_tot[lab]) << 16) + 64'(vocab_r) * 64'(beta_r);
        numd = (64'(dl_cnt[d*ltgs_pkg::NUM_LABELS+lab]) << 16) + 64'(alpha_r);
        if (den == 0)
            f = (64'd1 << 25) - 1;
        else
        begin
            f = (numw << 24) / den;
            if (f > (64'd1 << 25) - 1) f = (64'd1 << 25) - 1;
        end
        return (f * numd) >> 16;
    endfunction

    task automatic sample_label(input ltgs_pkg::in_item_t it);
        int labs [16];
        logic [63:0] wt [16];
        logic [63:0] total, cum, u;
        int k, d, w, s, idx, nl, old, wi, di;
        ltgs_pkg::out_item_t r;
        k = 0;
        s = it.token_slot; d = it.doc_id; w = it.word_id;
        u = 64'(it.random_value);
        for (int l = 0; l < 16; l++)
            if (it.label_mask[l]) begin labs[k] = l; k++; end
        if (k == 0) begin labs[0] = 0; k = 1; end
        if (it.operation == ltgs_pkg::OP_INIT)
        begin
            idx = int'((u * k) >> 16);
            if (idx >= k) idx = k - 1;
            nl = labs[idx];
            if (doc_tot[d] != '1) doc_tot[d]++;
        end
        else
        begin
            old = tok_lab[s];
            wi = w*ltgs_pkg::NUM_LABELS+old; di = d*ltgs_pkg::NUM_LABELS+old;
            if (wl_cnt[wi] != 0) wl_cnt[wi]--;
            if (dl_cnt[di] != 0) dl_cnt[di]--;
            if (lab_tot[old] != 0) lab_tot[old]--;
            total = 0; cum = 0;
            for (int l = 0; l < k; l++) begin wt[l] = weigh(d, w, labs[l]); total += wt[l]; end
            nl = labs[0];
            for (int l = 0; l < k; l++)
            begin
                cum += wt[l];
                if ((cum << 16) >= u * total) begin nl = labs[l]; break; end
            end
        end
        wi = w*ltgs_pkg::NUM_LABELS+nl; di = d*ltgs_pkg::NUM_LABELS+nl;
        if (wl_cnt[wi] != '1) wl_cnt[wi]++;
        if (dl_cnt[di] != '1) dl_cnt[di]++;
        if (lab_tot[nl] != '1) lab_tot[nl]++;
        tok_lab[s] = 4'(nl);
        r.new_label = 4'(nl);
        r.slot_echo = it.token_slot;
        label_queue = {label_queue, r};
    endtask

    initial
    begin
        fail_count = 0;
        alpha_r = 24'd32768; beta_r = 24'd655; vocab_r = 11'd1024;
        foreach (wl_cnt[i]) wl_cnt[i] = '0;
        foreach (dl_cnt[i]) dl_cnt[i] = '0;
        foreach (lab_tot[i]) lab_tot[i] = '0;
        foreach (doc_tot[i]) doc_tot[i] = '0;
        foreach (tok_lab[i]) tok_lab[i] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_idx == ltgs_pkg::REG_ALPHA) alpha_r = cfg_val[23:0];
                else if (cfg_idx == ltgs_pkg::REG_BETA) beta_r = cfg_val[23:0];
                else if (cfg_idx == ltgs_pkg::REG_VOCAB) vocab_r = cfg_val[10:0];
            end
            if (in_valid && !in_stall) sample_label(in_item);
            if (out_valid && !out_stall)
            begin
                if (label_queue.size() == 0)
                begin
                    $display("%0t: unexpected item, actual label %0d slot %0d", $time,
                             out_item.new_label, out_item.slot_echo);
                    fail_count++;
                end
                else
                begin
                    ltgs_pkg::out_item_t e;
                    e = label_queue.pop_front();
                    if (e.new_label !== out_item.new_label)
                    begin
                        $display("%0t: new_label expected %0d actual %0d", $time,
                                 e.new_label, out_item.new_label);
                        fail_count++;
                    end
                    if (e.slot_echo !== out_item.slot_echo)
                    begin
                        $display("%0t: slot_echo expected %0d actual %0d", $time,
                                 e.slot_echo, out_item.slot_echo);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/labeled_topic_gibbs_sampler_top_tb.sv =====
// testbench top for the labeled-topic gibbs sampler: stimulus, register writes and verdict
`timescale 1ns / 1ps

module labeled_topic_gibbs_sampler_top_tb;

    localparam int IDLE_LIMIT = 200000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    ltgs_pkg::in_item_t in_item;
    ltgs_pkg::out_item_t out_item;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    int fail_count, pending;
    logic hold_long;
    int idle_cycles = 0;
    int n_init, n_resample;

    // slots written so far, so a resample never reads an unwritten slot
    logic [15:0] written_slots [$];

    labeled_topic_gibbs_sampler_top dut (.*);

    ltgs_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[3:2]),
        .cfg_val(pwdata), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // receiver side
    initial
    begin
        int g;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_long) out_stall <= 1'b1;
            else
            begin
                g = gap_len();
                if ($urandom_range(0, 3) == 0 && g > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog: no progress");
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(input ltgs_pkg::in_item_t it);
        @(negedge clk);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.operation == ltgs_pkg::OP_INIT) n_init++; else n_resample++;
        written_slots = {written_slots, it.token_slot};
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic ltgs_pkg::in_item_t rand_item(input bit small_ids);
        ltgs_pkg::in_item_t it;
        it.operation = (written_slots.size() > 0 && $urandom_range(0, 3) != 0)
                       ? ltgs_pkg::OP_RESAMPLE : ltgs_pkg::OP_INIT;
        if (it.operation == ltgs_pkg::OP_RESAMPLE)
            it.token_slot = written_slots[$urandom_range(0, written_slots.size()-1)];
        else
            it.token_slot = small_ids ? 16'($urandom_range(0, 63)) : 16'($urandom);
        it.doc_id = small_ids ? 8'($urandom_range(0, 7)) : 8'($urandom);
        it.word_id = small_ids ? 10'($urandom_range(0, 15)) : 10'($urandom);
        case ($urandom_range(0, 3))
            0: it.label_mask = 16'(1 << $urandom_range(0, 15));
            1: it.label_mask = 16'($urandom_range(1, 15) << $urandom_range(0, 12));
            default: it.label_mask = 16'($urandom);
        endcase
        it.random_value = 16'($urandom);
        return it;
    endfunction

    initial
    begin
        ltgs_pkg::in_item_t it;
        int phase;
        rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        hold_long = 1'b0; n_init = 0; n_resample = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and both operations at reset settings
        it = '{ltgs_pkg::OP_INIT, 16'd0, 8'd0, 10'd0, 16'h0001, 16'h0000}; send_item(it);
        it = '{ltgs_pkg::OP_INIT, 16'hFFFF, 8'hFF, 10'h3FF, 16'hFFFF, 16'hFFFF}; send_item(it);
        it = '{ltgs_pkg::OP_INIT, 16'd1, 8'd0, 10'd0, 16'h8000, 16'h8000}; send_item(it);
        it = '{ltgs_pkg::OP_INIT, 16'd2, 8'd0, 10'd0, 16'h0000, 16'h1234}; send_item(it);
        it = '{ltgs_pkg::OP_INIT, 16'd3, 8'd0, 10'd0, 16'hFFFF, 16'h0000}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd0, 8'd0, 10'd0, 16'hFFFF, 16'h0000}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'hFFFF, 8'hFF, 10'h3FF, 16'hFFFF, 16'hFFFF};
        send_item(it);
        // old label no longer allowed
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd1, 8'd0, 10'd0, 16'h0001, 16'h7FFF}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd2, 8'd0, 10'd0, 16'h0000, 16'hFFFF}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd3, 8'd0, 10'd0, 16'h5555, 16'hAAAA}; send_item(it);
        drain();
        // zero priors give a zero denominator on empty labels
        reg_write(ltgs_pkg::REG_ALPHA, 32'd0);
        reg_write(ltgs_pkg::REG_BETA, 32'd0);
        reg_write(ltgs_pkg::REG_VOCAB, 32'd1);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd3, 8'd0, 10'd0, 16'hFFFF, 16'h4000}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd0, 8'd0, 10'd0, 16'hF0F0, 16'hFFFF}; send_item(it);
        drain();
        reg_write(ltgs_pkg::REG_ALPHA, 32'hFFFFFF);
        reg_write(ltgs_pkg::REG_BETA, 32'hFFFFFF);
        reg_write(ltgs_pkg::REG_VOCAB, 32'd1024);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'd1, 8'd0, 10'd0, 16'hFFFF, 16'h9000}; send_item(it);
        it = '{ltgs_pkg::OP_RESAMPLE, 16'hFFFF, 8'hFF, 10'h3FF, 16'h00FF, 16'h0001};
        send_item(it);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin reg_write(ltgs_pkg::REG_ALPHA, 32'd32768);
                         reg_write(ltgs_pkg::REG_BETA, 32'd655);
                         reg_write(ltgs_pkg::REG_VOCAB, 32'd1024); end
                1: begin reg_write(ltgs_pkg::REG_ALPHA, 32'd1);
                         reg_write(ltgs_pkg::REG_BETA, 32'd1);
                         reg_write(ltgs_pkg::REG_VOCAB, 32'd1); end
                2: begin reg_write(ltgs_pkg::REG_ALPHA, 32'hFFFFFF);
                         reg_write(ltgs_pkg::REG_BETA, 32'd0);
                         reg_write(ltgs_pkg::REG_VOCAB, 32'd512); end
                default: begin reg_write(ltgs_pkg::REG_ALPHA, $urandom_range(0, 32'hFFFFFF));
                         reg_write(ltgs_pkg::REG_BETA, $urandom_range(0, 32'hFFFFFF));
                         reg_write(ltgs_pkg::REG_VOCAB, $urandom_range(1, 1024)); end
            endcase
            for (int n = 0; n < 250; n++)
            begin
                // long receiver hold while the sender keeps offering items
                if (phase == 1 && n == 50)
                begin
                    hold_long = 1'b1;
                    fork
                        begin repeat (3000) @(negedge clk); hold_long = 1'b0; end
                    join_none
                end
                send_item(rand_item(phase != 3));
                repeat (gap_len()) @(negedge clk);
            end
            drain();
        end

        $display("covered %0d init and %0d resample items over nine register settings",
                 n_init, n_resample);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== labeled_topic_gibbs_sampler_top.f =====
rtl/ltgs_pkg.sv
rtl/ltgs_cfg.sv
rtl/ltgs_div.sv
rtl/ltgs_mem.sv
rtl/labeled_topic_gibbs_sampler_top.sv
rtl/ltgs_checker.sv
test/ltgs_checker.sv
test/labeled_topic_gibbs_sampler_top_tb.sv
